FILE: rtl/token_lexer_macros.svh
// assertion macros shared by the token lexer modules
`ifndef TOKEN_LEXER_MACROS_SVH
`define TOKEN_LEXER_MACROS_SVH
`ifndef SYNTHESIS
`define TLEX_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("token lexer check failed");
`define TLEX_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("token lexer check failed");
`define TLEX_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("token lexer check failed");
`else
`define TLEX_ASSERT(label, clk, rst, prop)
`define TLEX_ASSERT_IMPL(label, clk, rst, ante, cons)
`define TLEX_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

FILE: rtl/tlex_pkg.sv
// types and constants of the token lexer
package tlex_pkg;

   localparam int OFFSET_BITS = 20;
   localparam int LENGTH_BITS = 16;
   localparam int BURST_MAX   = 3;

   localparam logic [7:0] CH_PERCENT    = 8'h25;
   localparam logic [7:0] CH_HASH       = 8'h23;
   localparam logic [7:0] CH_DOLLAR     = 8'h24;
   localparam logic [7:0] CH_UNDERSCORE = 8'h5F;

   typedef enum logic [3:0] {
      KIND_END     = 4'd0,
      KIND_PERCENT = 4'd1,
      KIND_DOLLAR  = 4'd2,
      KIND_EQUAL   = 4'd3,
      KIND_SEMI    = 4'd4,
      KIND_COMMA   = 4'd5,
      KIND_LPAREN  = 4'd6,
      KIND_RPAREN  = 4'd7,
      KIND_LBRACE  = 4'd8,
      KIND_RBRACE  = 4'd9,
      KIND_COLOUR  = 4'd10,
      KIND_NUMBER  = 4'd11,
      KIND_IDENT   = 4'd12,
      KIND_ERROR   = 4'd13
   } kind_type;

   typedef struct packed {
      logic [7:0] byte_value;
      logic       is_last;
   } req_type;

   typedef struct packed {
      kind_type                token_kind;
      logic [OFFSET_BITS-1:0]  token_start;
      logic [LENGTH_BITS-1:0]  token_length;
      logic                    last_of_run;
   } rsp_type;

   // all tokens produced by one request, in order
   typedef struct packed {
      rsp_type [BURST_MAX-1:0] tok;
      logic [1:0]              count;
   } burst_type;

endpackage

FILE: rtl/tlex_scan.sv
// scanner state and per-byte token decode
`include "token_lexer_macros.svh"
module tlex_scan
   import tlex_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      req_fire,
   input  req_type   req_data,
   output burst_type burst
);

   typedef enum logic [2:0] {
      MODE_IDLE    = 3'd0,
      MODE_PCT     = 3'd1,
      MODE_COMMENT = 3'd2,
      MODE_COLOUR  = 3'd3,
      MODE_NUMBER  = 3'd4,
      MODE_IDENT   = 3'd5,
      MODE_DONE    = 3'd6
   } mode_type;

   mode_type               mode_ff,  mode_in;
   logic [OFFSET_BITS-1:0] start_ff, start_in;
   logic [LENGTH_BITS-1:0] len_ff,   len_in;
   logic [OFFSET_BITS-1:0] off_ff,   off_in;

   logic [OFFSET_BITS-1:0] off_next;
   logic [7:0]             b;
   logic                   fresh;
   logic [1:0]             n;

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= 8'h30) && (c <= 8'h39);
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A)) ||
             (c == CH_UNDERSCORE);
   endfunction

   function automatic logic is_hex(input logic [7:0] c);
      return is_digit(c) || ((c >= 8'h61) && (c <= 8'h66)) ||
             ((c >= 8'h41) && (c <= 8'h46));
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
   endfunction

   function automatic kind_type single_kind(input logic [7:0] c);
      kind_type k;
      unique case (c)
         CH_DOLLAR: k = KIND_DOLLAR;
         8'h3D:     k = KIND_EQUAL;
         8'h3B:     k = KIND_SEMI;
         8'h2C:     k = KIND_COMMA;
         8'h28:     k = KIND_LPAREN;
         8'h29:     k = KIND_RPAREN;
         8'h7B:     k = KIND_LBRACE;
         8'h7D:     k = KIND_RBRACE;
         default:   k = KIND_ERROR;
      endcase
      return k;
   endfunction

   function automatic logic has_pending(input mode_type m);
      return (m == MODE_PCT) || (m == MODE_COLOUR) || (m == MODE_NUMBER) ||
             (m == MODE_IDENT);
   endfunction

   function automatic kind_type pending_kind(input mode_type m);
      kind_type k;
      case (m)
         MODE_PCT:    k = KIND_PERCENT;
         MODE_COLOUR: k = KIND_COLOUR;
         MODE_NUMBER: k = KIND_NUMBER;
         default:     k = KIND_IDENT;
      endcase
      return k;
   endfunction

   function automatic rsp_type mk_tok(input kind_type k,
                                      input logic [OFFSET_BITS-1:0] s,
                                      input logic [LENGTH_BITS-1:0] l);
      rsp_type t;
      t.token_kind   = k;
      t.token_start  = s;
      t.token_length = l;
      t.last_of_run  = 1'b0;
      return t;
   endfunction

   assign b        = req_data.byte_value;
   assign off_next = off_ff + OFFSET_BITS'(1);

   always_comb begin
      mode_in   = mode_ff;
      start_in  = start_ff;
      len_in    = len_ff;
      off_in    = off_next;
      fresh     = 1'b0;
      n         = '0;
      burst.tok = '0;

      if (mode_ff != MODE_DONE) begin
         unique case (mode_ff)
            MODE_PCT: begin
               if (b == CH_PERCENT) begin
                  mode_in = MODE_COMMENT;
               end else begin
                  fresh = 1'b1;
               end
            end
            MODE_COMMENT: begin
               if ((b == 8'h0A) || (b == 8'h0D)) begin
                  mode_in = MODE_IDLE;
               end else if (b == 8'h00) begin
                  burst.tok[n] = mk_tok(KIND_END, off_ff, LENGTH_BITS'(1));
                  n = n + 2'd1;
                  mode_in = MODE_DONE;
               end
            end
            MODE_COLOUR: fresh = !is_hex(b);
            MODE_NUMBER: fresh = !is_digit(b);
            MODE_IDENT:  fresh = !(is_alpha(b) || is_digit(b));
            default: begin
               mode_in = MODE_IDLE;
               fresh   = 1'b1;
            end
         endcase

         // continuing a run
         if (!fresh && ((mode_ff == MODE_COLOUR) || (mode_ff == MODE_NUMBER) ||
                        (mode_ff == MODE_IDENT))) begin
            if (len_in != '1) begin
               len_in = len_in + LENGTH_BITS'(1);
            end
         end

         // close the pending token, then scan this byte from scratch
         if (fresh) begin
            if (has_pending(mode_in)) begin
               burst.tok[n] = mk_tok(pending_kind(mode_in), start_in, len_in);
               n = n + 2'd1;
            end
            mode_in = MODE_IDLE;
            if (is_space(b)) begin
               mode_in = MODE_IDLE;
            end else if (b == 8'h00) begin
               burst.tok[n] = mk_tok(KIND_END, off_ff, LENGTH_BITS'(1));
               n = n + 2'd1;
               mode_in = MODE_DONE;
            end else if (b == CH_PERCENT || b == CH_HASH || is_digit(b) ||
                         is_alpha(b)) begin
               start_in = off_ff;
               len_in   = LENGTH_BITS'(1);
               if (b == CH_PERCENT)   mode_in = MODE_PCT;
               else if (b == CH_HASH) mode_in = MODE_COLOUR;
               else if (is_digit(b))  mode_in = MODE_NUMBER;
               else                   mode_in = MODE_IDENT;
            end else begin
               burst.tok[n] = mk_tok(single_kind(b), off_ff, LENGTH_BITS'(1));
               n = n + 2'd1;
            end
         end

         // end of file flushes whatever is open
         if (req_data.is_last && (mode_in != MODE_DONE)) begin
            if (has_pending(mode_in)) begin
               burst.tok[n] = mk_tok(pending_kind(mode_in), start_in, len_in);
               n = n + 2'd1;
            end
            mode_in = MODE_IDLE;
            burst.tok[n] = mk_tok(KIND_END, off_next, LENGTH_BITS'(1));
            n = n + 2'd1;
         end
      end

      if (req_data.is_last) begin
         mode_in  = MODE_IDLE;
         start_in = '0;
         len_in   = '0;
         off_in   = '0;
      end

      if (n != 2'd0) begin
         burst.tok[n - 2'd1].last_of_run = 1'b1;
      end
      burst.count = n;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_IDLE;
         start_ff <= '0;
         len_ff   <= '0;
         off_ff   <= '0;
      end else if (req_fire) begin
         mode_ff  <= mode_in;
         start_ff <= start_in;
         len_ff   <= len_in;
         off_ff   <= off_in;
      end
   end

   `TLEX_ASSERT_IMPL(a_done_silent, clock, reset, mode_ff == MODE_DONE, burst.count == 2'd0)
   `TLEX_ASSERT_NEXT(a_last_rewinds, clock, reset, req_fire && req_data.is_last, off_ff == '0)

endmodule

FILE: rtl/tlex_rsp_queue.sv
// four-entry result queue, takes a whole burst at once
`include "token_lexer_macros.svh"
module tlex_rsp_queue
   import tlex_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  burst_type burst,
   output logic      room,
   output logic      rsp_valid,
   input  logic      rsp_stall,
   output rsp_type   rsp_data
);

   rsp_type    q_ff [4];
   logic [1:0] rd_ptr_ff, rd_ptr_in;
   logic [1:0] wr_ptr_ff, wr_ptr_in;
   logic [2:0] cnt_ff,    cnt_in;
   logic       pop;

   assign rsp_valid = (cnt_ff != 3'd0);
   assign rsp_data  = q_ff[rd_ptr_ff];
   assign pop       = rsp_valid && !rsp_stall;
   // a burst of up to three tokens always fits
   assign room      = (cnt_ff <= 3'd1);

   always_comb begin
      rd_ptr_in = pop  ? rd_ptr_ff + 2'd1 : rd_ptr_ff;
      wr_ptr_in = push ? wr_ptr_ff + burst.count : wr_ptr_ff;
      cnt_in    = cnt_ff + (push ? {1'b0, burst.count} : 3'd0) - {2'b00, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < BURST_MAX; i++) begin
         if (push && (2'(i) < burst.count)) begin
            q_ff[wr_ptr_ff + 2'(i)] <= burst.tok[i];
         end
      end
   end

   `TLEX_ASSERT(a_cnt_bound, clock, reset, cnt_ff <= 3'd4)
   `TLEX_ASSERT_IMPL(a_push_room, clock, reset, push, cnt_ff <= 3'd1)
   `TLEX_ASSERT_NEXT(a_pop_drains, clock, reset, pop && !push, cnt_ff == $past(cnt_ff) - 3'd1)

endmodule

FILE: rtl/token_lexer.sv
// token lexer top level
//
// Streaming lexer: one source byte per request on req_data, tokens out on
// rsp_data as kind, start offset, length and a last-of-run flag.
// Both channels use valid/stall; a transfer happens when valid is high and
// stall is low on a rising clock edge.
// The tokens caused by a byte are written into the result queue when the byte
// is taken and leave it on rsp in order, one token per cycle while rsp_stall is low.
// Throughput: one byte per cycle while bytes give at most one token each
// and the receiver keeps up. A byte that closes a token and also yields
// one (or ends the file) gives two or three tokens; the four-entry result
// queue then holds req_stall high until at most one token is left in it.
// When rsp_stall is high the queue keeps its tokens and req_stall rises as
// soon as two or more are waiting.
// Reset (synchronous, active high) returns the scanner to idle at offset
// zero and empties the queue. The last byte of a file does the same to the
// scanner, so the next byte starts a new file at offset zero.
module token_lexer
   import tlex_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic      req_fire;
   logic      room;
   burst_type burst;

   assign req_stall = !room;
   assign req_fire  = req_valid && room;

   tlex_scan u_scan (
      .clock    (clock),
      .reset    (reset),
      .req_fire (req_fire),
      .req_data (req_data),
      .burst    (burst)
   );

   tlex_rsp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_fire),
      .burst     (burst),
      .room      (room),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

FILE: tb/token_checker.sv
// token predictor and result-channel checker for the token lexer
`timescale 1ns / 100ps
module token_checker
   import tlex_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_stall,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_stall,
   input  rsp_type rsp_data,
   output int      errors,
   output int      waiting
);

   typedef enum logic [2:0] {
      LEX_IDLE,
      LEX_PERCENT,
      LEX_COMMENT,
      LEX_COLOUR,
      LEX_NUMBER,
      LEX_IDENT,
      LEX_DONE
   } lex_mode_type;

   lex_mode_type           mode;
   logic [OFFSET_BITS-1:0] run_start;
   logic [OFFSET_BITS-1:0] cursor;
   logic [LENGTH_BITS-1:0] run_len;
   rsp_type                burst[$];
   rsp_type                tokens_due[$];
   rsp_type                expected_tok;

   function automatic logic is_digit(logic [7:0] b);
      return b >= "0" && b <= "9";
   endfunction

   function automatic logic is_word_start(logic [7:0] b);
      return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == CH_UNDERSCORE;
   endfunction

   function automatic void add_token(kind_type kind, logic [OFFSET_BITS-1:0] start,
                                     logic [LENGTH_BITS-1:0] len);
      rsp_type t;
      t.token_kind   = kind;
      t.token_start  = start;
      t.token_length = len;
      t.last_of_run  = 1'b0;
      burst = {burst, t};
   endfunction

   // a comment closes without a token
   function automatic void close_run();
      case (mode)
         LEX_PERCENT: add_token(KIND_PERCENT, run_start, LENGTH_BITS'(1));
         LEX_COLOUR:  add_token(KIND_COLOUR, run_start, run_len);
         LEX_NUMBER:  add_token(KIND_NUMBER, run_start, run_len);
         LEX_IDENT:   add_token(KIND_IDENT, run_start, run_len);
         default: ;
      endcase
      mode = LEX_IDLE;
   endfunction

   function automatic void open_run(lex_mode_type m, logic [OFFSET_BITS-1:0] at);
      mode      = m;
      run_start = at;
      run_len   = LENGTH_BITS'(1);
   endfunction

   function automatic void grow_run();
      if (run_len != '1) run_len = run_len + 1'b1;
   endfunction

   function automatic void lex_byte(req_type r);
      logic [7:0]             b;
      logic [OFFSET_BITS-1:0] at;
      logic                   rescan;
      b      = r.byte_value;
      at     = cursor;
      rescan = 1'b0;
      burst.delete();
      if (mode != LEX_DONE) begin
         case (mode)
            LEX_PERCENT: begin
               if (b == CH_PERCENT) mode = LEX_COMMENT;
               else begin
                  close_run();
                  rescan = 1'b1;
               end
            end
            LEX_COMMENT: begin
               if (b == 8'h0A || b == 8'h0D) mode = LEX_IDLE;
               else if (b == 8'h00) begin
                  add_token(KIND_END, at, LENGTH_BITS'(1));
                  mode = LEX_DONE;
               end
            end
            LEX_COLOUR: begin
               if (is_digit(b) || (b >= "a" && b <= "f") || (b >= "A" && b <= "F")) grow_run();
               else begin
                  close_run();
                  rescan = 1'b1;
               end
            end
            LEX_NUMBER: begin
               if (is_digit(b)) grow_run();
               else begin
                  close_run();
                  rescan = 1'b1;
               end
            end
            LEX_IDENT: begin
               if (is_word_start(b) || is_digit(b)) grow_run();
               else begin
                  close_run();
                  rescan = 1'b1;
               end
            end
            default: begin
               mode   = LEX_IDLE;
               rescan = 1'b1;
            end
         endcase
         if (rescan) begin
            if (b == 8'h00) begin
               add_token(KIND_END, at, LENGTH_BITS'(1));
               mode = LEX_DONE;
            end else if (b == CH_PERCENT) open_run(LEX_PERCENT, at);
            else if (b == CH_HASH) open_run(LEX_COLOUR, at);
            else if (is_digit(b)) open_run(LEX_NUMBER, at);
            else if (is_word_start(b)) open_run(LEX_IDENT, at);
            else if (b != " " && (b < 8'h09 || b > 8'h0D)) begin
               case (b)
                  CH_DOLLAR: add_token(KIND_DOLLAR, at, LENGTH_BITS'(1));
                  "=":       add_token(KIND_EQUAL, at, LENGTH_BITS'(1));
                  ";":       add_token(KIND_SEMI, at, LENGTH_BITS'(1));
                  ",":       add_token(KIND_COMMA, at, LENGTH_BITS'(1));
                  "(":       add_token(KIND_LPAREN, at, LENGTH_BITS'(1));
                  ")":       add_token(KIND_RPAREN, at, LENGTH_BITS'(1));
                  "{":       add_token(KIND_LBRACE, at, LENGTH_BITS'(1));
                  "}":       add_token(KIND_RBRACE, at, LENGTH_BITS'(1));
                  default:   add_token(KIND_ERROR, at, LENGTH_BITS'(1));
               endcase
            end
         end
         // end of file flushes and places the end token one past the byte
         if (r.is_last && mode != LEX_DONE) begin
            close_run();
            add_token(KIND_END, at + 1'b1, LENGTH_BITS'(1));
         end
      end
      if (r.is_last) begin
         mode      = LEX_IDLE;
         run_start = '0;
         run_len   = '0;
         cursor    = '0;
      end else begin
         cursor = at + 1'b1;
      end
      if (burst.size() > 0) burst[burst.size() - 1].last_of_run = 1'b1;
      tokens_due = {tokens_due, burst};
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         mode      = LEX_IDLE;
         run_start = '0;
         run_len   = '0;
         cursor    = '0;
         errors    = 0;
         tokens_due.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (tokens_due.size() == 0) begin
               errors++;
               $display("%0t: extra token: expected none, got %0d/%h/%0d/%b",
                        $time, rsp_data.token_kind, rsp_data.token_start,
                        rsp_data.token_length, rsp_data.last_of_run);
            end else begin
               expected_tok = tokens_due.pop_front();
               if (rsp_data.token_kind !== expected_tok.token_kind ||
                   rsp_data.token_start !== expected_tok.token_start ||
                   rsp_data.token_length !== expected_tok.token_length ||
                   rsp_data.last_of_run !== expected_tok.last_of_run) begin
                  errors++;
                  $display("%0t: token mismatch: expected %0d/%h/%0d/%b, got %0d/%h/%0d/%b",
                           $time, expected_tok.token_kind, expected_tok.token_start,
                           expected_tok.token_length, expected_tok.last_of_run,
                           rsp_data.token_kind, rsp_data.token_start,
                           rsp_data.token_length, rsp_data.last_of_run);
               end
            end
         end
         if (req_valid && !req_stall) lex_byte(req_data);
      end
      waiting = tokens_due.size();
   end

endmodule

FILE: tb/testbench.sv
// stimulus, receiver and verdict for the token lexer
`timescale 1ns / 100ps
module testbench
   import tlex_pkg::*;
();

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;
   int      errors;
   int      waiting;

   logic idle_on     = 1'b0;
   logic pressure_on = 1'b0;
   int   bytes_sent  = 0;

   logic [7:0] punct_chars [8] = '{CH_DOLLAR, "=", ";", ",", "(", ")", "{", "}"};
   logic [7:0] blank_chars [6] = '{8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};

   always #5 clock = ~clock;

   token_lexer dut (
      .clock,
      .reset,
      .req_valid,
      .req_stall,
      .req_data,
      .rsp_valid,
      .rsp_stall,
      .rsp_data
   );

   token_checker lex_check (
      .clock,
      .reset,
      .req_valid,
      .req_stall,
      .req_data,
      .rsp_valid,
      .rsp_stall,
      .rsp_data,
      .errors,
      .waiting
   );

   task automatic send_byte(input logic [7:0] b, input logic last);
      int gap;
      gap = (idle_on && !pressure_on && $urandom_range(0, 4) == 0) ? $urandom_range(1, 19) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_data  <= '{byte_value: b, is_last: last};
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      bytes_sent++;
   endtask

   // one file: the final byte carries is_last
   task automatic send_seq(input logic [7:0] seq[$]);
      foreach (seq[i]) send_byte(seq[i], i == seq.size() - 1);
   endtask

   function automatic logic [7:0] word_char(bit with_digits);
      int r;
      r = $urandom_range(0, with_digits ? 62 : 52);
      if (r < 26) return 8'("a" + r);
      if (r < 52) return 8'("A" + r - 26);
      if (r == 52) return CH_UNDERSCORE;
      return 8'("0" + r - 53);
   endfunction

   task automatic random_file();
      logic [7:0] text[$];
      int         r;
      if ($urandom_range(0, 7) == 0) begin
         // raw noise
         repeat ($urandom_range(1, 16)) text = {text, 8'($urandom_range(0, 255))};
      end else begin
         repeat ($urandom_range(1, 10)) begin
            case ($urandom_range(0, 15))
               0, 1, 11: begin
                  text = {text, word_char(1'b0)};
                  repeat ($urandom_range(0, 8)) text = {text, word_char(1'b1)};
               end
               2, 12: repeat ($urandom_range(1, 6)) text = {text, 8'("0" + $urandom_range(0, 9))};
               3: begin
                  text = {text, CH_HASH};
                  repeat ($urandom_range(0, 7)) begin
                     r = $urandom_range(0, 21);
                     text = {text, (r < 10 ? 8'("0" + r) : r < 16 ? 8'("a" + r - 10) :
                                    8'("A" + r - 16))};
                  end
               end
               6: text = {text, CH_PERCENT};
               7: begin
                  text = {text, CH_PERCENT, CH_PERCENT};
                  repeat ($urandom_range(0, 6)) text = {text, 8'($urandom_range(8'h20, 8'h7E))};
                  if ($urandom_range(0, 3) != 0)
                     text = {text, ($urandom_range(0, 1) ? 8'h0A : 8'h0D)};
               end
               8: repeat ($urandom_range(1, 3)) text = {text, blank_chars[$urandom_range(0, 5)]};
               9: text = {text, 8'($urandom_range(0, 255))};
               10: begin
                  // nul ends the file early, the rest is junk
                  text = {text, 8'h00};
                  repeat ($urandom_range(0, 4)) text = {text, 8'($urandom_range(0, 255))};
               end
               default: text = {text, punct_chars[$urandom_range(0, 7)]};
            endcase
            if ($urandom_range(0, 1) == 0) text = {text, blank_chars[$urandom_range(0, 5)]};
         end
         case ($urandom_range(0, 5))
            0: text = {text, 8'h00};
            1: text = {text, CH_PERCENT, CH_PERCENT, 8'("z")};
            default: ;
         endcase
      end
      send_seq(text);
   endtask

   // receiver: random stall bursts, plus one long hold-off under pressure
   initial begin
      bit held;
      held = 1'b0;
      forever begin
         @(negedge clock);
         if (pressure_on && !held) begin
            held = 1'b1;
            rsp_stall <= 1'b1;
            repeat (300) @(negedge clock);
            rsp_stall <= 1'b0;
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 19)) @(negedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin
      #40_000_000;
      $display("testbench: errors");
      $finish;
   end

   initial begin
      logic [7:0] seq[$];
      int         base;
      repeat (5) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      idle_on = 1'b1;
      seq = {"(", CH_PERCENT, "a", CH_UNDERSCORE, "9", " ", CH_HASH, "F", "a", "0", ",",
             "1", "2", CH_DOLLAR, 8'hFF};
      send_seq(seq);
      // comment running into the last byte
      seq = {"=", ";", "{", "}", ")", CH_PERCENT, CH_PERCENT, "z"};
      send_seq(seq);
      seq = {CH_PERCENT, 8'h00, 8'h7F};
      send_seq(seq);
      seq = {"1", "2", "3", "4", ";"};
      send_seq(seq);

      pressure_on = 1'b1;
      seq.delete();
      repeat (40) seq = {seq, punct_chars[$urandom_range(0, 7)]};
      send_seq(seq);
      pressure_on = 1'b0;

      base = bytes_sent;
      while (bytes_sent - base < 400) begin
         idle_on = (bytes_sent - base < 320);
         random_file();
      end
      idle_on = 1'b0;

      @(negedge clock) req_valid <= 1'b0;
      while (waiting != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (errors == 0 && waiting == 0)
         $display("testbench: clean");
      else
         $display("testbench: errors");
      $finish;
   end

endmodule

FILE: files.f
+incdir+rtl
rtl/tlex_pkg.sv
rtl/tlex_scan.sv
rtl/tlex_rsp_queue.sv
rtl/token_lexer.sv
tb/token_checker.sv
tb/testbench.sv
